>>> design/dndo_pkg.sv
// Shared types and constants for the day-number date offset block.
`default_nettype none

package dndo_pkg;

  // Field widths of the stream payloads.
  localparam int CMD_W  = 2;
  localparam int DN_W   = 17;
  localparam int AMT_W  = 16;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;

  // Packed stream widths; the data widths are padded to whole bytes.
  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 1;

  // Working width of the shared adder: holds a signed day count well past
  // the largest span plus the largest week shift.
  localparam int AW = 21;

  // Width of a days-in-year value.
  localparam int YD_W = 9;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_DAYS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEEKS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_YEARS = 2'd2;

  // Month numbers: first, last, and those with special lengths.
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // First year of the Gregorian century rule.
  localparam logic [YEAR_W-1:0] GREG_START = 12'd1583;

  // Lengths of years and months.
  localparam logic [YD_W-1:0]  DAYS_YEAR  = 9'd365;
  localparam logic [YD_W-1:0]  DAYS_LEAP  = 9'd366;
  localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_FEB_L = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_30    = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_31    = 5'd31;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_OFFSET,
    ST_SPLIT_Y,
    ST_SPLIT_M,
    ST_SHIFT,
    ST_TARGET,
    ST_BUILD_Y,
    ST_BUILD_M,
    ST_BUILD_D,
    ST_FINISH
  } state_t;

  // Commands to the calendar walker.
  typedef struct packed {
    logic init;
    logic year_inc;
    logic month_inc;
  } cal_ctrl_t;

  // Current position and lengths reported by the calendar walker.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [YD_W-1:0]   year_days;
    logic [DAY_W-1:0]  month_days;
  } cal_stat_t;

endpackage

`default_nettype wire

>>> design/day_number_date_offset_top.sv
// Day-number date offset: shifts a day number by days, weeks or years.
// A day or week shift walks the years and months of the result while splitting it; a year
// shift also walks the start date and the target year.
// Throughput: one transaction at a time; the next is accepted in the cycle after the result loads.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
`default_nettype none

module day_number_date_offset_top #(
  parameter int BASE_YEAR = 1900,
  parameter int YEAR_SPAN = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // day_number [16:0], amount [32:17], zero [39:33]
  input  wire logic [dndo_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // cmd [1:0], subtract [2]
  input  wire logic [dndo_pkg::S_USER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // new_day_number [16:0], new_day [21:17], new_month [25:22], new_year [37:26],
  // zero [39:38]
  output logic [dndo_pkg::M_DATA_W-1:0]        m_axis_tdata,
  // out_of_range [0]
  output logic [dndo_pkg::M_USER_W-1:0]        m_axis_tuser
);
  import dndo_pkg::*;

  // Span limits, worked out at elaboration.
  localparam int LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;
  localparam int PREV_YEAR = BASE_YEAR - 1;
  localparam int LEAPS = (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400) -
                         (PREV_YEAR / 4 - PREV_YEAR / 100 + PREV_YEAR / 400);
  localparam int MAX_DN = 365 * YEAR_SPAN + LEAPS;
  localparam logic signed [AW-1:0] MAX_DN_S = AW'(MAX_DN);
  localparam logic signed [AW-1:0] BASE_S   = AW'(BASE_YEAR);
  localparam logic signed [AW-1:0] LAST_S   = AW'(LAST_YEAR);

  state_t               state, state_next;
  logic [DN_W-1:0]      dn_q, dn_q_next;
  logic [AMT_W-1:0]     amt_q, amt_q_next;
  logic                 sub_q, sub_q_next;
  logic signed [AW-1:0] acc, acc_next;
  logic signed [AW-1:0] res, res_next;
  logic signed [AW-1:0] ny, ny_next;
  logic [DAY_W-1:0]     dsave, dsave_next;
  logic [MON_W-1:0]     msave, msave_next;
  logic                 bad, bad_next;
  logic                 final_pass, final_pass_next;

  logic                 out_valid;
  logic [M_DATA_W-1:0]  out_data;
  logic                 out_flag;
  logic                 out_load;

  logic signed [AW-1:0] alu_a, alu_b, alu_y;
  logic                 alu_sub;
  logic                 alu_pos;

  cal_ctrl_t            cal_ctrl;
  cal_stat_t            cal_stat;

  dndo_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  dndo_cal #(
    .BASE_YEAR (BASE_YEAR)
  ) u_cal (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cal_ctrl),
    .stat (cal_stat)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign alu_pos       = !alu_y[AW-1] && (alu_y != '0);

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    dn_q       <= dn_q_next;
    amt_q      <= amt_q_next;
    sub_q      <= sub_q_next;
    acc        <= acc_next;
    res        <= res_next;
    ny         <= ny_next;
    dsave      <= dsave_next;
    msave      <= msave_next;
    bad        <= bad_next;
    final_pass <= final_pass_next;
  end

  // Next state, shared-unit operands and calendar commands.
  always_comb begin
    state_next      = state;
    dn_q_next       = dn_q;
    amt_q_next      = amt_q;
    sub_q_next      = sub_q;
    acc_next        = acc;
    res_next        = res;
    ny_next         = ny;
    dsave_next      = dsave;
    msave_next      = msave;
    bad_next        = bad;
    final_pass_next = final_pass;
    alu_a           = acc;
    alu_b           = '0;
    alu_sub         = 1'b0;
    cal_ctrl        = '0;
    out_load        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          dn_q_next       = s_axis_tdata[DN_W-1:0];
          amt_q_next      = s_axis_tdata[DN_W+AMT_W-1:DN_W];
          sub_q_next      = s_axis_tuser[CMD_W];
          bad_next        = 1'b0;
          final_pass_next = 1'b0;
          unique case (s_axis_tuser[CMD_W-1:0])
            CMD_DAYS: begin
              acc_next   = AW'(s_axis_tdata[DN_W+AMT_W-1:DN_W]);
              state_next = ST_OFFSET;
            end
            CMD_WEEKS: begin
              state_next = ST_STEP;
            end
            CMD_YEARS: begin
              if ((s_axis_tdata[DN_W-1:0] == '0) ||
                  (AW'(s_axis_tdata[DN_W-1:0]) > MAX_DN_S)) begin
                bad_next   = 1'b1;
                state_next = ST_FINISH;
              end else begin
                acc_next      = AW'(s_axis_tdata[DN_W-1:0]);
                cal_ctrl.init = 1'b1;
                state_next    = ST_SPLIT_Y;
              end
            end
            default: begin
              bad_next   = 1'b1;
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      // Week count times seven, as eight times less one.
      ST_STEP: begin
        alu_a      = AW'({amt_q, 3'b000});
        alu_b      = AW'(amt_q);
        alu_sub    = 1'b1;
        acc_next   = alu_y;
        state_next = ST_OFFSET;
      end

      // Apply the day offset and check it against the span.
      ST_OFFSET: begin
        alu_a   = AW'(dn_q);
        alu_b   = acc;
        alu_sub = sub_q;
        if (!alu_pos || (alu_y > MAX_DN_S)) begin
          bad_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          acc_next        = alu_y;
          res_next        = alu_y;
          final_pass_next = 1'b1;
          cal_ctrl.init   = 1'b1;
          state_next      = ST_SPLIT_Y;
        end
      end

      // Peel whole years off the day count.
      ST_SPLIT_Y: begin
        alu_b   = AW'(cal_stat.year_days);
        alu_sub = 1'b1;
        if (alu_pos) begin
          acc_next          = alu_y;
          cal_ctrl.year_inc = 1'b1;
        end else begin
          state_next = ST_SPLIT_M;
        end
      end

      // Peel whole months off what is left.
      ST_SPLIT_M: begin
        alu_b   = AW'(cal_stat.month_days);
        alu_sub = 1'b1;
        if (alu_pos && (cal_stat.month != MON_DEC)) begin
          acc_next           = alu_y;
          cal_ctrl.month_inc = 1'b1;
        end else begin
          dsave_next = acc[DAY_W-1:0];
          msave_next = cal_stat.month;
          state_next = final_pass ? ST_FINISH : ST_SHIFT;
        end
      end

      // Move the year.
      ST_SHIFT: begin
        alu_a      = AW'(cal_stat.year);
        alu_b      = AW'(amt_q);
        alu_sub    = sub_q;
        ny_next    = alu_y;
        state_next = ST_TARGET;
      end

      // Check the target year and start rebuilding from the base.
      ST_TARGET: begin
        if ((ny < BASE_S) || (ny > LAST_S)) begin
          bad_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          acc_next      = '0;
          cal_ctrl.init = 1'b1;
          state_next    = ST_BUILD_Y;
        end
      end

      // Sum the lengths of the years before the target.
      ST_BUILD_Y: begin
        alu_b = AW'(cal_stat.year_days);
        if (cal_stat.year == ny[YEAR_W-1:0]) begin
          state_next = ST_BUILD_M;
        end else begin
          acc_next          = alu_y;
          cal_ctrl.year_inc = 1'b1;
        end
      end

      // Sum the lengths of the months before the target month.
      ST_BUILD_M: begin
        alu_b = AW'(cal_stat.month_days);
        if (cal_stat.month == msave) begin
          state_next = ST_BUILD_D;
        end else begin
          acc_next           = alu_y;
          cal_ctrl.month_inc = 1'b1;
        end
      end

      // Add the day of month, then split the rebuilt number again.
      ST_BUILD_D: begin
        alu_b = AW'(dsave);
        if (alu_y > MAX_DN_S) begin
          bad_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          acc_next        = alu_y;
          res_next        = alu_y;
          final_pass_next = 1'b1;
          cal_ctrl.init   = 1'b1;
          state_next      = ST_SPLIT_Y;
        end
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: holds one result until the downstream transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      if (bad) begin
        out_data <= '0;
        out_flag <= 1'b1;
      end else begin
        out_data <= {2'b00, cal_stat.year, msave, dsave, res[DN_W-1:0]};
        out_flag <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_flag;

endmodule

`default_nettype wire

>>> design/dndo_addsub.sv
// Shared signed adder and subtractor used by the arithmetic steps of the sequencer.
`default_nettype none

module dndo_addsub (
  input  wire logic signed [dndo_pkg::AW-1:0] a,
  input  wire logic signed [dndo_pkg::AW-1:0] b,
  input  wire logic                           sub,
  output logic signed [dndo_pkg::AW-1:0]      y
);
  import dndo_pkg::*;

  // Subtraction is addition of the inverted operand with a carry in.
  logic signed [AW-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign y    = a + b_op + AW'(sub);

endmodule

`default_nettype wire

>>> design/dndo_cal.sv
// Calendar walker: steps year and month and reports their lengths.
`default_nettype none

module dndo_cal #(
  parameter int BASE_YEAR = 1900
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dndo_pkg::cal_ctrl_t ctrl,
  output dndo_pkg::cal_stat_t      stat
);
  import dndo_pkg::*;

  localparam logic [YEAR_W-1:0] BASE_Y = YEAR_W'(BASE_YEAR);
  localparam logic [1:0]        BASE_M4   = 2'(BASE_YEAR % 4);
  localparam logic [6:0]        BASE_M100 = 7'(BASE_YEAR % 100);
  localparam logic [8:0]        BASE_M400 = 9'(BASE_YEAR % 400);

  logic [YEAR_W-1:0] year;
  logic [MON_W-1:0]  month;
  logic [1:0]        m4;
  logic [6:0]        m100;
  logic [8:0]        m400;
  logic              leap;

  // Year and month position, with running remainders of the year.
  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= BASE_Y;
      month <= MON_JAN;
      m4    <= BASE_M4;
      m100  <= BASE_M100;
      m400  <= BASE_M400;
    end else if (ctrl.init) begin
      year  <= BASE_Y;
      month <= MON_JAN;
      m4    <= BASE_M4;
      m100  <= BASE_M100;
      m400  <= BASE_M400;
    end else begin
      if (ctrl.year_inc) begin
        year <= year + YEAR_W'(1);
        m4   <= m4 + 2'd1;
        m100 <= (m100 == 7'd99) ? 7'd0 : m100 + 7'd1;
        m400 <= (m400 == 9'd399) ? 9'd0 : m400 + 9'd1;
      end
      if (ctrl.month_inc) begin
        month <= month + MON_W'(1);
      end
    end
  end

  // Leap rule: every fourth year, except Gregorian centuries not divisible by 400.
  always_comb begin
    if (m4 != 2'd0) begin
      leap = 1'b0;
    end else if (year < GREG_START) begin
      leap = 1'b1;
    end else begin
      leap = !((m100 == 7'd0) && (m400 != 9'd0));
    end
  end

  // Lengths of the current year and month.
  always_comb begin
    stat.year      = year;
    stat.month     = month;
    stat.year_days = leap ? DAYS_LEAP : DAYS_YEAR;
    case (month) inside
      MON_FEB:                           stat.month_days = leap ? DAYS_FEB_L : DAYS_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: stat.month_days = DAYS_30;
      default:                           stat.month_days = DAYS_31;
    endcase
  end

endmodule

`default_nettype wire
